@@ sv/dlf_pkg.sv @@
`default_nettype none

package dlf_pkg;

    // Default sizes of the layer.
    localparam int MAX_NEURONS = 16;
    localparam int MAX_INPUTS  = 64;

    // Action codes of an input transaction.
    localparam logic [1:0] ACT_WEIGHT  = 2'd0;
    localparam logic [1:0] ACT_BIAS    = 2'd1;
    localparam logic [1:0] ACT_ELEMENT = 2'd2;

    // Activation modes; the fourth code behaves as linear.
    localparam logic [1:0] MODE_THRESH = 2'd0;
    localparam logic [1:0] MODE_LEAKY  = 2'd1;
    localparam logic [1:0] MODE_LINEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_INPUTS  = 2'd1;
    localparam logic [1:0] CFG_NEURONS = 2'd2;

    // Configuration reset values.
    localparam logic [1:0] MODE_RESET    = MODE_LEAKY;
    localparam logic [6:0] INPUTS_RESET  = 7'd64;
    localparam logic [4:0] NEURONS_RESET = 5'd16;

    // Leaky slope is LEAK_NUM / 2^LEAK_SHIFT; 1.0 in Q8.24.
    localparam int          LEAK_NUM   = 41;
    localparam int          LEAK_SHIFT = 12;
    localparam logic [31:0] ONE_Q24    = 32'h0100_0000;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         neuron;
        logic [5:0]         position;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         neuron_index;
        logic signed [31:0] activation;
        logic               last;
    } t_out_item;

    // Input element travelling along the row of processing elements.
    typedef struct packed {
        logic               vld;
        logic               last;
        logic signed [15:0] x;
    } t_tok;

    // Commands broadcast to every processing element.
    typedef struct packed {
        logic start;
        logic shift;
    } t_pe_ctl;

    // Weight or bias write aimed at one processing element.
    typedef struct packed {
        logic               we_w;
        logic               we_b;
        logic signed [15:0] data;
    } t_pe_wr;

endpackage

`default_nettype wire

@@ sv/dense_layer_forward_top.sv @@
// Load transactions (weight, bias) and elements that do not complete the vector are taken while idle.
// The completing element starts a pass that streams the vector through the row of neuron
// elements; results then leave one per cycle while the receiver is ready.
// No input transaction is taken from the completing element until the last result is loaded.
// Reset (synchronous, active low) clears control state and restores mode, input_count and
// neuron_count; weights, biases and the input vector hold nothing defined until written.
`default_nettype none

module dense_layer_forward_top #(
    parameter int MAX_NEURONS = dlf_pkg::MAX_NEURONS,
    parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [1:0]           i_cfg_idx,
    input  wire [6:0]           i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire dlf_pkg::t_in_item i_in,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output dlf_pkg::t_out_item  o_out
);

    localparam int IDX_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int CNT_W  = $clog2(MAX_INPUTS + 1);
    localparam int ACC_W  = 32 + $clog2(MAX_INPUTS);
    localparam int NIDX_W = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int NCNT_W = $clog2(MAX_NEURONS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_COMP  = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [1:0]        r_mode;
    logic [6:0]        r_icnt;
    logic [4:0]        r_ncnt;
    logic [CNT_W-1:0]  r_elems, n_elems;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [NIDX_W-1:0] r_on;
    logic signed [15:0] r_xbuf [MAX_INPUTS];
    logic signed [15:0] r_xrd;
    logic              r_tok_vld;
    logic              r_tok_last;
    logic [IDX_W-1:0]  r_tok_idx;
    logic              r_out_vld;
    dlf_pkg::t_out_item r_out;

    logic [CNT_W-1:0]  w_len;
    logic [NCNT_W-1:0] w_ncnt;
    logic              w_accept;
    logic              w_elem;
    logic              w_start;
    logic              w_feed_last;
    logic              w_load;
    logic              w_drain_last;
    logic [IDX_W-1:0]  w_pos;
    logic signed [31:0] w_act;
    dlf_pkg::t_pe_ctl  w_ctl;

    dlf_pkg::t_tok           w_tok  [MAX_NEURONS+1];
    logic [IDX_W-1:0]        w_idx  [MAX_NEURONS+1];
    logic signed [ACC_W-1:0] w_acc  [MAX_NEURONS+1];
    logic signed [15:0]      w_bsh  [MAX_NEURONS+1];
    logic                    w_done [MAX_NEURONS];
    dlf_pkg::t_pe_wr         w_wr   [MAX_NEURONS];

    // Effective counts: zero acts as one, large values clip to the maximum.
    always_comb begin
        if (r_icnt == '0) begin
            w_len = CNT_W'(1);
        end else if (32'(r_icnt) > MAX_INPUTS) begin
            w_len = CNT_W'(MAX_INPUTS);
        end else begin
            w_len = CNT_W'(r_icnt);
        end
        if (r_ncnt == '0) begin
            w_ncnt = NCNT_W'(1);
        end else if (32'(r_ncnt) > MAX_NEURONS) begin
            w_ncnt = NCNT_W'(MAX_NEURONS);
        end else begin
            w_ncnt = NCNT_W'(r_ncnt);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= dlf_pkg::MODE_RESET;
            r_icnt <= dlf_pkg::INPUTS_RESET;
            r_ncnt <= dlf_pkg::NEURONS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dlf_pkg::CFG_MODE:    r_mode <= i_cfg_data[1:0];
                dlf_pkg::CFG_INPUTS:  r_icnt <= i_cfg_data;
                dlf_pkg::CFG_NEURONS: r_ncnt <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Input transaction decode.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pos      = IDX_W'(i_in.position);
    assign w_elem     = w_accept && i_in.action == dlf_pkg::ACT_ELEMENT
                        && 32'(i_in.position) < MAX_INPUTS;
    assign w_start    = w_elem && !(r_elems + CNT_W'(1) < w_len);

    always_comb begin
        n_elems = r_elems;
        if (w_elem) begin
            n_elems = w_start ? '0 : r_elems + CNT_W'(1);
        end
    end

    // Input vector memory; read one element a cycle while feeding the row.
    always_ff @(posedge i_clk) begin
        if (w_elem) begin
            r_xbuf[w_pos] <= i_in.value;
        end
        if (r_state == S_COMP) begin
            r_xrd <= r_xbuf[r_rd_idx];
        end
        r_tok_idx  <= r_rd_idx;
        r_tok_last <= w_feed_last;
    end

    assign w_feed_last  = (CNT_W'(r_rd_idx) + CNT_W'(1) == w_len);
    assign w_load       = (r_state == S_DRAIN) && (!r_out_vld || i_out_ready);
    assign w_drain_last = (NCNT_W'(r_on) + NCNT_W'(1) == w_ncnt);

    // Sequencer: feed the vector, wait for the row to finish, drain results.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_start) n_state = S_COMP;
            S_COMP:  if (w_feed_last) n_state = S_WAIT;
            S_WAIT:  if (w_done[MAX_NEURONS-1]) n_state = S_DRAIN;
            S_DRAIN: if (w_load && w_drain_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_elems   <= '0;
            r_rd_idx  <= '0;
            r_on      <= '0;
            r_tok_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_elems   <= n_elems;
            r_tok_vld <= (r_state == S_COMP);
            if (w_start) begin
                r_rd_idx <= '0;
                r_on     <= '0;
            end else if (r_state == S_COMP) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end else if (w_load) begin
                r_on <= r_on + NIDX_W'(1);
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Output register, loaded from the head of the row.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.neuron_index <= 4'(r_on);
            r_out.activation   <= w_act;
            r_out.last         <= w_drain_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // Row of neuron elements.
    assign w_ctl.start = w_start;
    assign w_ctl.shift = w_load;

    assign w_tok[0].vld  = r_tok_vld;
    assign w_tok[0].last = r_tok_last;
    assign w_tok[0].x    = r_xrd;
    assign w_idx[0]      = r_tok_idx;
    assign w_acc[MAX_NEURONS] = '0;
    assign w_bsh[MAX_NEURONS] = '0;

    for (genvar k = 0; k < MAX_NEURONS; k++) begin : g_pe
        assign w_wr[k].we_w = w_accept && i_in.action == dlf_pkg::ACT_WEIGHT
                              && 32'(i_in.neuron) == k
                              && 32'(i_in.position) < MAX_INPUTS;
        assign w_wr[k].we_b = w_accept && i_in.action == dlf_pkg::ACT_BIAS
                              && 32'(i_in.neuron) == k;
        assign w_wr[k].data = i_in.value;

        dlf_cell #(
            .MAX_INPUTS (MAX_INPUTS)
        ) u_pe (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_wr     (w_wr[k]),
            .i_waddr  (w_pos),
            .i_tok    (w_tok[k]),
            .i_idx    (w_idx[k]),
            .i_acc_nb (w_acc[k+1]),
            .i_bsh_nb (w_bsh[k+1]),
            .o_tok    (w_tok[k+1]),
            .o_idx    (w_idx[k+1]),
            .o_acc    (w_acc[k]),
            .o_bsh    (w_bsh[k]),
            .o_done   (w_done[k])
        );
    end

    // Activation of the neuron at the head of the row.
    dlf_act #(
        .ACC_W (ACC_W)
    ) u_act (
        .i_mode (r_mode),
        .i_acc  (w_acc[0]),
        .i_bias (w_bsh[0]),
        .o_act  (w_act)
    );

    // The row reports completion only while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done[MAX_NEURONS-1] |-> r_state == S_WAIT)
        else $error("row finished outside the wait state");

    // Elements enter the row only in the cycle after a feed cycle.
    a_tok_from_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_vld |-> $past(r_state) == S_COMP)
        else $error("element token without a feed cycle");

    // Loading the final result returns the block to idle.
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_drain_last) |=> (r_state == S_IDLE && o_out.last && o_out_valid))
        else $error("drain did not end with the last result");

    // The drain never runs past the active neuron count.
    a_drain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> NCNT_W'(r_on) < w_ncnt)
        else $error("drain index beyond neuron count");

endmodule

`default_nettype wire

@@ sv/dlf_cell.sv @@
`default_nettype none

module dlf_cell #(
    parameter int MAX_INPUTS = dlf_pkg::MAX_INPUTS
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    input  wire dlf_pkg::t_pe_ctl                      i_ctl,
    input  wire dlf_pkg::t_pe_wr                       i_wr,
    input  wire [((MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1)-1:0] i_waddr,
    input  wire dlf_pkg::t_tok                         i_tok,
    input  wire [((MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1)-1:0] i_idx,
    input  wire signed [32+$clog2(MAX_INPUTS)-1:0]     i_acc_nb,
    input  wire signed [15:0]                          i_bsh_nb,
    output dlf_pkg::t_tok                              o_tok,
    output logic [((MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1)-1:0] o_idx,
    output logic signed [32+$clog2(MAX_INPUTS)-1:0]    o_acc,
    output logic signed [15:0]                         o_bsh,
    output logic                                       o_done
);

    localparam int IDX_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int ACC_W = 32 + $clog2(MAX_INPUTS);

    logic signed [15:0]      r_wmem [MAX_INPUTS];
    logic signed [15:0]      r_bias;
    logic signed [15:0]      r_bsh;
    logic signed [15:0]      r_w;
    logic                    r_a_vld;
    logic                    r_a_last;
    logic signed [15:0]      r_a_x;
    logic [IDX_W-1:0]        r_a_idx;
    logic signed [31:0]      r_prod;
    logic                    r_b_vld;
    logic                    r_b_last;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_done;

    // Weight memory: written by load transactions, read as the element passes.
    always_ff @(posedge i_clk) begin
        if (i_wr.we_w) begin
            r_wmem[i_waddr] <= i_wr.data;
        end
        if (i_tok.vld) begin
            r_w <= r_wmem[i_idx];
        end
    end

    // Bias of this neuron.
    always_ff @(posedge i_clk) begin
        if (i_wr.we_b) begin
            r_bias <= i_wr.data;
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_a_vld <= i_tok.vld;
            r_b_vld <= r_a_vld;
            r_done  <= r_b_vld & r_b_last;
        end
    end

    // Element hand-off to the neighbor and the registered product.
    always_ff @(posedge i_clk) begin
        r_a_last <= i_tok.last;
        r_a_x    <= i_tok.x;
        r_a_idx  <= i_idx;
        r_prod   <= r_a_x * r_w;
        r_b_last <= r_a_last;
    end

    // Accumulator: cleared at vector start, adds each product, shifted toward the output when draining.
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.start) begin
            r_acc <= '0;
            r_bsh <= r_bias;
        end else if (i_ctl.shift) begin
            r_acc <= i_acc_nb;
            r_bsh <= i_bsh_nb;
        end else if (r_b_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_tok  = {r_a_vld, r_a_last, r_a_x};
    assign o_idx  = r_a_idx;
    assign o_acc  = r_acc;
    assign o_bsh  = r_bsh;
    assign o_done = r_done;

endmodule

`default_nettype wire

@@ sv/dlf_act.sv @@
`default_nettype none

module dlf_act #(
    parameter int ACC_W = 32 + $clog2(dlf_pkg::MAX_INPUTS)
) (
    input  wire [1:0]               i_mode,
    input  wire signed [ACC_W-1:0]  i_acc,
    input  wire signed [15:0]       i_bias,
    output logic signed [31:0]      o_act
);

    localparam int SUM_W = ACC_W + 1;
    localparam int LK_W  = SUM_W + 6;
    localparam logic signed [LK_W-1:0] LEAK_K  = LK_W'(dlf_pkg::LEAK_NUM);
    localparam logic signed [LK_W-1:0] RND     = LK_W'((1 << dlf_pkg::LEAK_SHIFT) - 1);
    localparam logic signed [LK_W-1:0] SAT_HI  = LK_W'(32'sh7FFF_FFFF);
    localparam logic signed [LK_W-1:0] SAT_LO  = LK_W'(signed'(32'h8000_0000));

    logic signed [SUM_W-1:0] w_acc;
    logic signed [SUM_W-1:0] w_bq;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [LK_W-1:0]  w_lk;
    logic signed [LK_W-1:0]  w_lq;
    logic signed [LK_W-1:0]  w_pre;

    // Bias moves from Q4.12 to Q8.24 and is added to the dot product.
    assign w_acc = SUM_W'(i_acc);
    assign w_bq  = SUM_W'(i_bias) <<< dlf_pkg::LEAK_SHIFT;
    assign w_sum = w_acc + w_bq;

    // Negative leak: scale by 41/4096, rounding toward zero (input is never positive).
    assign w_lk = LK_W'(w_sum) * LEAK_K;
    assign w_lq = (w_lk + RND) >>> dlf_pkg::LEAK_SHIFT;

    always_comb begin
        w_pre = LK_W'(w_sum);
        if (i_mode == dlf_pkg::MODE_LEAKY && w_sum <= 0) begin
            w_pre = w_lq;
        end
    end

    // Mode select with saturation to 32 bits.
    always_comb begin
        unique case (i_mode)
            dlf_pkg::MODE_THRESH: begin
                o_act = (w_acc > w_bq) ? dlf_pkg::ONE_Q24 : 32'd0;
            end
            default: begin
                priority if (w_pre > SAT_HI) begin
                    o_act = 32'sh7FFF_FFFF;
                end else if (w_pre < SAT_LO) begin
                    o_act = signed'(32'h8000_0000);
                end else begin
                    o_act = 32'(w_pre);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

@@ test/dlf_checker.sv @@
`timescale 1ns / 100ps

module dlf_checker
    import dlf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [6:0]  i_cfg_data,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  t_in_item   i_in,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  t_out_item  i_out,
    output int         o_err_count,
    output int         o_pending
);

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // Shadow copy of the layer state and its configuration.
    logic signed [15:0] weight_mem [MAX_NEURONS*MAX_INPUTS];
    logic signed [15:0] bias_mem [MAX_NEURONS];
    logic signed [15:0] vec_mem [MAX_INPUTS];
    int unsigned        elem_seen;
    logic [1:0]         act_mode;
    logic [6:0]         vec_len_cfg;
    logic [4:0]         layer_width_cfg;

    // Activations still owed by the block, oldest first.
    t_out_item          pending_acts[$];

    // Zero counts act as one, counts beyond the array size saturate.
    function automatic int vec_len();
        if (vec_len_cfg == 0) return 1;
        if (vec_len_cfg > MAX_INPUTS) return MAX_INPUTS;
        return vec_len_cfg;
    endfunction

    function automatic int layer_width();
        if (layer_width_cfg == 0) return 1;
        if (layer_width_cfg > MAX_NEURONS) return MAX_NEURONS;
        return layer_width_cfg;
    endfunction

    // Exact Q8.24 dot product of one neuron, then the selected activation.
    function automatic logic signed [31:0] fire_neuron(int n, int len);
        longint acc;
        longint b;
        longint s;
        int     i;
        acc = 0;
        b = longint'(bias_mem[n]) * 4096;
        for (i = 0; i < len; i++) begin
            acc += longint'(vec_mem[i]) * longint'(weight_mem[n*MAX_INPUTS + i]);
        end
        if (act_mode == MODE_THRESH) begin
            return (acc > b) ? ONE_Q24 : 32'd0;
        end
        s = acc + b;
        // Negative leak rounds toward zero, as signed division does.
        if (act_mode == MODE_LEAKY && s <= 0) begin
            s = (s * LEAK_NUM) / (longint'(1) <<< LEAK_SHIFT);
        end
        if (s > SAT_HI) s = SAT_HI;
        if (s < SAT_LO) s = SAT_LO;
        return s[31:0];
    endfunction

    // Apply one accepted input transaction and queue the activations it causes.
    task automatic take_item(input t_in_item it);
        int        len;
        int        cnt;
        int        n;
        t_out_item r;
        case (it.action)
            ACT_WEIGHT: weight_mem[it.neuron*MAX_INPUTS + it.position] = it.value;
            ACT_BIAS:   bias_mem[it.neuron] = it.value;
            ACT_ELEMENT: begin
                vec_mem[it.position] = it.value;
                len = vec_len();
                if (elem_seen + 1 < len) begin
                    elem_seen++;
                end else begin
                    elem_seen = 0;
                    cnt = layer_width();
                    for (n = 0; n < cnt; n++) begin
                        r.neuron_index = 4'(n);
                        r.activation   = fire_neuron(n, len);
                        r.last         = (n + 1 == cnt);
                        pending_acts   = {pending_acts, r};
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            elem_seen       = 0;
            act_mode        = MODE_RESET;
            vec_len_cfg     = INPUTS_RESET;
            layer_width_cfg = NEURONS_RESET;
            o_err_count     = 0;
            pending_acts.delete();
        end else begin
            // Register writes.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:    act_mode = i_cfg_data[1:0];
                    CFG_INPUTS:  vec_len_cfg = i_cfg_data;
                    CFG_NEURONS: layer_width_cfg = i_cfg_data[4:0];
                    default: ;
                endcase
            end

            // Compare a result transaction against the oldest expectation.
            if (i_out_valid && i_out_ready) begin
                if (pending_acts.size() == 0) begin
                    o_err_count++;
                    $display("%0t: unexpected result: neuron %0d activation %0d last %0b",
                             $time, i_out.neuron_index, i_out.activation, i_out.last);
                end else begin
                    if (i_out.neuron_index !== pending_acts[0].neuron_index ||
                        i_out.activation !== pending_acts[0].activation ||
                        i_out.last !== pending_acts[0].last) begin
                        o_err_count++;
                        $display("%0t: mismatch: expected neuron %0d activation %0d last %0b",
                                 $time, pending_acts[0].neuron_index,
                                 pending_acts[0].activation, pending_acts[0].last);
                        $display("%0t:           actual neuron %0d activation %0d last %0b",
                                 $time, i_out.neuron_index, i_out.activation, i_out.last);
                    end
                    void'(pending_acts.pop_front());
                end
            end

            // Input transactions.
            if (i_in_valid && i_in_ready) begin
                take_item(i_in);
            end
        end
        o_pending = pending_acts.size();
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import dlf_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int DRAIN_CYCLES = MAX_INPUTS + MAX_NEURONS + 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 8;
    // Widest vector of the random phases; the first fill writes weights below this position.
    localparam int FILL_POS     = 4;

    // Codes without a package name: the unused action and the fourth mode.
    localparam logic [1:0] ACT_NONE        = 2'd3;
    localparam logic [1:0] MODE_ALT_LINEAR = 2'd3;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_idx   = CFG_MODE;
    logic [6:0] cfg_data  = 7'd0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    t_out_item  out_item;
    int         err_count;
    int         pending;

    // Stimulus controls for the sender and the receiver.
    int         cur_len  = MAX_INPUTS;
    bit         no_gaps  = 1'b0;
    bit         hold_req = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    dense_layer_forward_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    dlf_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_item),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item mk(logic [1:0] act, int nrn, int pos, logic [15:0] val);
        t_in_item it;
        it.action   = act;
        it.neuron   = 4'(nrn);
        it.position = 6'(pos);
        it.value    = val;
        return it;
    endfunction

    // Q4.12 values with the extremes weighted up.
    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly vector elements aimed at the active positions, some loads, a little noise.
    function automatic t_in_item rand_item();
        int r;
        int pos;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85) pos = $urandom_range(0, cur_len - 1);
        else pos = $urandom_range(0, MAX_INPUTS - 1);
        if (r < 70) return mk(ACT_ELEMENT, $urandom_range(0, 15), pos, rand_value());
        if (r < 85) return mk(ACT_WEIGHT, $urandom_range(0, 15), pos, rand_value());
        if (r < 95) return mk(ACT_BIAS, $urandom_range(0, 15), pos, rand_value());
        return mk(ACT_NONE, $urandom_range(0, 15), pos, rand_value());
    endfunction

    // Offer one input transaction and hold it until accepted.
    task automatic send_item(input t_in_item it);
        int gap;
        @(negedge clk);
        in_item  = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop offering, wait for every owed result, then let a pass in flight finish.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    task automatic configure(input logic [1:0] m, input int ic, input int nc);
        settle();
        write_reg(CFG_MODE, {5'd0, m});
        write_reg(CFG_INPUTS, 7'(ic));
        write_reg(CFG_NEURONS, 7'(nc & 31));
        if (ic == 0) cur_len = 1;
        else if (ic > MAX_INPUTS) cur_len = MAX_INPUTS;
        else cur_len = ic;
    endtask

    // Receiver: random stalls, or one long hold-off when asked.
    initial begin : rx_side
        int stall;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else if (no_gaps) begin
                out_ready = 1'b1;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    out_ready = 1'b1;
                end else begin
                    out_ready = 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    initial begin : stimulus
        int idx;
        int n;
        int ph;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Only the input count leaves its reset value, so the first vector runs in the
        // reset mode across every neuron. Weights, biases and elements are filled up to
        // the widest vector of the random phases.
        write_reg(CFG_INPUTS, 7'(FILL_POS));
        cur_len = FILL_POS;
        for (n = 0; n < MAX_NEURONS; n++) begin
            for (idx = 0; idx < FILL_POS; idx++) begin
                send_item(mk(ACT_WEIGHT, n, idx, rand_value()));
            end
            send_item(mk(ACT_BIAS, n, 0, rand_value()));
        end
        for (idx = 0; idx < FILL_POS; idx++) begin
            send_item(mk(ACT_ELEMENT, 0, idx, rand_value()));
        end

        // Saturation at both ends in linear mode.
        configure(MODE_LINEAR, 2, 2);
        send_item(mk(ACT_WEIGHT, 0, 0, 16'h8000));
        send_item(mk(ACT_WEIGHT, 0, 1, 16'h8000));
        send_item(mk(ACT_WEIGHT, 1, 0, 16'h7FFF));
        send_item(mk(ACT_WEIGHT, 1, 1, 16'h7FFF));
        send_item(mk(ACT_BIAS, 0, 0, 16'h7FFF));
        send_item(mk(ACT_BIAS, 1, 0, 16'h8000));
        send_item(mk(ACT_ELEMENT, 0, 0, 16'h8000));
        send_item(mk(ACT_ELEMENT, 0, 1, 16'h8000));

        // The unused action is dropped; an element beyond the count still counts.
        send_item(mk(ACT_NONE, 15, 63, 16'hFFFF));
        send_item(mk(ACT_ELEMENT, 0, 5, 16'h1234));
        send_item(mk(ACT_ELEMENT, 0, 0, 16'h7FFF));

        // Threshold: a sum equal to the bias gives zero, just above it gives one.
        configure(MODE_THRESH, 1, 1);
        send_item(mk(ACT_WEIGHT, 0, 0, 16'h1000));
        send_item(mk(ACT_BIAS, 0, 0, 16'h1000));
        send_item(mk(ACT_ELEMENT, 0, 0, 16'h1000));
        send_item(mk(ACT_BIAS, 0, 0, 16'h0FFF));
        send_item(mk(ACT_ELEMENT, 0, 0, 16'h1000));

        // Leaky relu on a negative sum and on an exact zero.
        configure(MODE_LEAKY, 1, 1);
        send_item(mk(ACT_BIAS, 0, 0, 16'h8000));
        send_item(mk(ACT_ELEMENT, 0, 0, 16'h1000));
        send_item(mk(ACT_BIAS, 0, 0, 16'hF000));
        send_item(mk(ACT_ELEMENT, 0, 0, 16'h1000));

        // Lower the count below the elements already taken: the next one completes.
        configure(MODE_LINEAR, 8, 4);
        for (idx = 0; idx < 5; idx++) send_item(mk(ACT_ELEMENT, 0, idx, rand_value()));
        configure(MODE_LINEAR, 3, 4);
        send_item(mk(ACT_ELEMENT, 0, 5, rand_value()));

        // Long hold-off on the result side while elements keep coming back to back.
        configure(MODE_LEAKY, 1, 16);
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        for (idx = 0; idx < 8; idx++) send_item(mk(ACT_ELEMENT, 0, 0, rand_value()));
        no_gaps  = 1'b0;
        settle();

        // Random phases, each with its own register setting.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: configure(MODE_THRESH, 0, 0);
                1: configure(MODE_ALT_LINEAR, FILL_POS - 1, 31);
                2: configure(MODE_LEAKY, FILL_POS, MAX_NEURONS);
                3: configure(MODE_LINEAR, 1, 1);
                default: configure(2'($urandom_range(0, 3)), $urandom_range(1, FILL_POS),
                                   $urandom_range(1, 16));
            endcase
            no_gaps = (ph % 4 == 3);
            for (idx = 0; idx < PHASE_ITEMS; idx++) send_item(rand_item());
            no_gaps = 1'b0;
        end

        // Drain and give the verdict.
        @(negedge clk);
        in_valid = 1'b0;
        n = 0;
        while (pending != 0 && n < 200000) begin
            @(negedge clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (err_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
